// ----- design/lpc_pkg.sv -----
package lpc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int PAGE_W = 31;
	localparam int CAP_W = 5;
	localparam int HIT_W = 32;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [PAGE_W-1:0] page_t;
	typedef page_t [MAX_ENTRIES-1:0] slots_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic hit;
		logic full;
		logic [MAX_ENTRIES-1:0] shift_mask;
		cnt_t keep;
		cnt_t drop;
		cnt_t occ_next;
	} ctrl_t;

endpackage

// ----- design/lru_page_cache_hit_tracker_top.sv -----
// A word accepted into the input register moves to the result register, which drives the
// outputs, unless out_stall holds a result there. Throughput: one word per cycle while out_stall
// holds no result; the lookup, shift and count are combinational between the input register and the result register.
// Reset: arst_n clears the occupancy, the hit total and both stage valid flags at once and
// sets capacity to 16; the page slots are not cleared, since empty slots are never read.
module lru_page_cache_hit_tracker_top import lpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PAGE_W-1:0] page_number,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic             evicted_valid,
	output logic [PAGE_W-1:0] evicted_page,
	output logic [HIT_W-1:0] hit_total
);

	logic             valid_s1;
	page_t            page_s1;
	logic             valid_s2;
	logic             hit_s2;
	logic             evicted_valid_s2;
	page_t            evicted_page_s2;
	logic [HIT_W-1:0] hit_total_q;
	logic [CAP_W-1:0] cap_q;
	cnt_t             occ_q;
	slots_t           slots_q;
	slots_t           slots_next;
	page_t            evicted_next;
	ctrl_t            ctrl;
	logic             advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	lpc_lookup u_lookup (
		.slots    (slots_q),
		.occ      (occ_q),
		.capacity (cap_q),
		.page     (page_s1),
		.ctrl     (ctrl)
	);

	lpc_shift u_shift (
		.slots        (slots_q),
		.occ          (occ_q),
		.page         (page_s1),
		.ctrl         (ctrl),
		.slots_next   (slots_next),
		.evicted_page (evicted_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			page_s1 <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			occ_q       <= '0;
			hit_total_q <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			occ_q    <= ctrl.occ_next;
			if (ctrl.hit && (hit_total_q != '1)) begin
				hit_total_q <= hit_total_q + HIT_W'(1);
			end
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slots_q          <= slots_next;
			hit_s2           <= ctrl.hit;
			evicted_valid_s2 <= ctrl.full && !ctrl.hit;
			evicted_page_s2  <= evicted_next;
		end
	end

	assign out_valid     = valid_s2;
	assign hit           = hit_s2;
	assign evicted_valid = evicted_valid_s2;
	assign evicted_page  = evicted_page_s2;
	assign hit_total     = hit_total_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= MAX_ENTRIES)
		else $error("occupancy beyond the built depth");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(hit_s2 && evicted_valid_s2))
		else $error("hit and eviction in the same word");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		hit_total_q >= $past(hit_total_q))
		else $error("hit total went down");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled without a held result");

endmodule

// ----- design/lpc_lookup.sv -----
module lpc_lookup import lpc_pkg::*; (
	input  slots_t           slots,
	input  cnt_t             occ,
	input  logic [CAP_W-1:0] capacity,
	input  page_t            page,
	output ctrl_t            ctrl
);

	logic [MAX_ENTRIES-1:0] match;
	cnt_t cap_eff;

	always_comb begin
		if (capacity == '0) begin
			cap_eff = cnt_t'(1);
		end else if (int'(capacity) > MAX_ENTRIES) begin
			cap_eff = cnt_t'(MAX_ENTRIES);
		end else begin
			cap_eff = cnt_t'(capacity);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = (cnt_t'(i) < occ) && (slots[i] == page);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			ctrl.shift_mask[i] = 1'b0;
			for (int j = 0; j <= i; j++) begin
				ctrl.shift_mask[i] = ctrl.shift_mask[i] | match[j];
			end
		end
		ctrl.hit  = |match;
		ctrl.full = (occ >= cap_eff);
		ctrl.keep = cap_eff - cnt_t'(1);
		ctrl.drop = occ - ctrl.keep;
		if (ctrl.hit) begin
			ctrl.occ_next = occ;
		end else if (ctrl.full) begin
			ctrl.occ_next = cap_eff;
		end else begin
			ctrl.occ_next = occ + cnt_t'(1);
		end
	end

endmodule

// ----- design/lpc_shift.sv -----
module lpc_shift import lpc_pkg::*; (
	input  slots_t slots,
	input  cnt_t   occ,
	input  page_t  page,
	input  ctrl_t  ctrl,
	output slots_t slots_next,
	output page_t  evicted_page
);

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slots_next[i] = slots[i];
			if (ctrl.hit) begin
				if (cnt_t'(i + 1) == occ) begin
					slots_next[i] = page;
				end else if (ctrl.shift_mask[i] && (cnt_t'(i + 1) < occ)) begin
					slots_next[i] = slots[(i + 1) % MAX_ENTRIES];
				end
			end else if (ctrl.full) begin
				if (cnt_t'(i) < ctrl.keep) begin
					for (int j = 0; j < MAX_ENTRIES; j++) begin
						if (j == i + int'(ctrl.drop)) begin
							slots_next[i] = slots[j];
						end
					end
				end else if (cnt_t'(i) == ctrl.keep) begin
					slots_next[i] = page;
				end
			end else if (cnt_t'(i) == occ) begin
				slots_next[i] = page;
			end
		end
	end

	assign evicted_page = (ctrl.full && !ctrl.hit) ? slots[0] : '0;

endmodule

// ----- tb/sv/lru_page_cache_hit_tracker_top_tb.sv -----
`timescale 1ns / 100ps

module lru_page_cache_hit_tracker_top_tb;
	import lpc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 250;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 115;
	localparam page_t PAGE_MAX = '1;

	typedef struct packed {
		logic hit;
		logic ev_valid;
		page_t ev_page;
		logic [HIT_W-1:0] total;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	page_t page_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic evicted_valid;
	page_t evicted_page;
	logic [HIT_W-1:0] hit_total;

	page_t lru_pages [MAX_ENTRIES];
	int unsigned lru_fill = 0;
	logic [HIT_W-1:0] hits_so_far = '0;
	logic [CAP_W-1:0] cap_setting = CAP_RESET;

	page_t pending_pages [$];
	lookup_t awaited [$];
	logic word_taken = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	lru_page_cache_hit_tracker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.page_number(page_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.hit_total(hit_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned cap_in_force(logic [CAP_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_ENTRIES)
			return MAX_ENTRIES;
		return 32'(c);
	endfunction

	function automatic lookup_t apply_reference(page_t pg);
		lookup_t res;
		int unsigned eff;
		int unsigned n;
		int unsigned found;
		int unsigned keep;
		int unsigned drop;
		res = '0;
		eff = cap_in_force(cap_setting);
		n = lru_fill;
		found = n;
		for (int unsigned i = 0; i < n; i++) begin
			if (found == n && lru_pages[i] == pg)
				found = i;
		end
		if (found < n) begin
			res.hit = 1'b1;
			for (int unsigned i = found; i + 1 < n; i++)
				lru_pages[i] = lru_pages[i + 1];
			lru_pages[n - 1] = pg;
			if (hits_so_far != '1)
				hits_so_far = hits_so_far + HIT_W'(1);
		end else begin
			if (n >= eff) begin
				keep = eff - 1;
				drop = n - keep;
				res.ev_valid = 1'b1;
				res.ev_page = lru_pages[0];
				for (int unsigned i = 0; i < keep; i++)
					lru_pages[i] = lru_pages[i + drop];
				n = keep;
			end
			lru_pages[n] = pg;
			n++;
		end
		lru_fill = n;
		res.total = hits_so_far;
		return res;
	endfunction

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		cap_setting = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_pages.size() != 0 || in_valid || awaited.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Sender: a new word is offered only once the previous one has been taken.
	always @(negedge clk) begin
		logic next_valid;
		page_t next_page;
		next_valid = in_valid;
		next_page = page_number;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!in_valid || word_taken) begin
			next_valid = 1'b0;
			if (pending_pages.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_valid = 1'b1;
				next_page = pending_pages.pop_front();
			end
		end
		in_valid <= next_valid;
		page_number <= next_page;
	end

	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		lookup_t want;
		logic in_acc;
		logic out_acc;
		in_acc = arst_n && in_valid && !in_stall;
		out_acc = arst_n && out_valid && !out_stall;
		word_taken = in_acc;
		if (out_acc) begin
			if (awaited.size() == 0) begin
				flag_error($sformatf("unexpected word: hit=%0b ev=%0b page=%h total=%0d",
					hit, evicted_valid, evicted_page, hit_total));
			end else begin
				want = awaited.pop_front();
				if (hit !== want.hit || evicted_valid !== want.ev_valid ||
						evicted_page !== want.ev_page || hit_total !== want.total)
					flag_error($sformatf({"mismatch: expected hit=%0b ev=%0b page=%h total=%0d,",
						" got hit=%0b ev=%0b page=%h total=%0d"},
						want.hit, want.ev_valid, want.ev_page, want.total,
						hit, evicted_valid, evicted_page, hit_total));
			end
		end
		if (in_acc)
			awaited.push_back(apply_reference(page_number));
		if (in_acc || out_acc || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int cap_plan [PHASES];
		page_t page_pool [MAX_ENTRIES + 6];
		int pool_n;
		int pick;
		cap_plan = '{31, 1, 16, 7, 0, 17, 4, 16, 2, 10, 24, 5};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Fill all sixteen slots, re-reference a few, then force an eviction.
		pending_pages.push_back('0);
		pending_pages.push_back(PAGE_MAX);
		pending_pages.push_back(31'h2AAA_AAAA);
		pending_pages.push_back(31'h5555_5555);
		pending_pages.push_back('0);
		pending_pages.push_back(PAGE_MAX);
		for (int i = 1; i <= 12; i++)
			pending_pages.push_back(page_t'(i));
		pending_pages.push_back(31'h2AAA_AAAA);
		pending_pages.push_back(31'h0123_4567);
		wait_idle();

		// Capacity lowered below occupancy: old entries still hit until the next miss.
		write_capacity(CAP_W'(3));
		pending_pages.push_back(page_t'(5));
		pending_pages.push_back(31'h7654_3210);
		wait_idle();

		write_capacity(CAP_W'(0));
		pending_pages.push_back(31'h4000_0000);
		pending_pages.push_back(31'h4000_0000);
		pending_pages.push_back(31'h0000_0001);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(CAP_W'(cap_plan[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 85; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 85; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			pool_n = $urandom_range(cap_in_force(CAP_W'(cap_plan[ph])) + 6, 1);
			for (int i = 0; i < pool_n; i++)
				page_pool[i] = page_t'($urandom);
			if (ph == 4)
				hold_ask++;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				pick = $urandom_range(99);
				if (pick < 75)
					pending_pages.push_back(page_pool[$urandom_range(pool_n - 1)]);
				else if (pick < 90)
					pending_pages.push_back(page_t'($urandom));
				else if (pick < 95)
					pending_pages.push_back(page_t'(1) << $urandom_range(PAGE_W - 1));
				else
					pending_pages.push_back($urandom_range(1) ? PAGE_MAX : page_t'(0));
			end
			wait_idle();
		end

		repeat (5) @(posedge clk);
		if (awaited.size() != 0)
			flag_error($sformatf("%0d words never arrived", awaited.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
